@@ rtl/core/pva_pkg.sv @@
// Shared constants, types and item codes of the voice allocator.
package pva_pkg;

    // Default pool and note store sizes
    localparam int VOICES_DEF     = 16;
    localparam int NOTES_DEF      = 128;
    localparam int FADE_STEPS_DEF = 256;

    // Fixed field widths of the words on the channels
    localparam int KIND_W  = 3;
    localparam int NOTE_W  = 8;
    localparam int INDEX_W = 4;
    localparam int MASK_W  = 16;

    typedef logic [KIND_W-1:0] kind_t;

    // Item kinds
    localparam kind_t KIND_NOTE_ON  = 3'd0;
    localparam kind_t KIND_NOTE_OFF = 3'd1;
    localparam kind_t KIND_ALL_OFF  = 3'd2;
    localparam kind_t KIND_TICK     = 3'd3;
    localparam kind_t KIND_PRESENCE = 3'd4;

endpackage

@@ rtl/core/pva_if.sv @@
// Request and response channels of the voice allocator.
interface pva_req_if;
    import pva_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [NOTE_W-1:0]   note_number;
    logic                present_flag;

    modport source (output valid, output kind, output note_number, output present_flag,
                    input ready);
    modport sink   (input valid, input kind, input note_number, input present_flag,
                    output ready);
endinterface

interface pva_rsp_if;
    import pva_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  voice_index;
    logic                voice_found;
    logic [MASK_W-1:0]   active_mask;
    logic [MASK_W-1:0]   releasing_mask;

    modport source (output valid, output voice_index, output voice_found,
                    output active_mask, output releasing_mask, input ready);
    modport sink   (input valid, input voice_index, input voice_found,
                    input active_mask, input releasing_mask, output ready);
endinterface

@@ rtl/core/poly_voice_allocator_release.sv @@
// Polyphonic voice allocator with release fade: top level.
//
//  channel  dir  word                                              handshake
//  -------  ---  ------------------------------------------------  ---------
//  req      in   kind, note_number, present_flag                   valid/ready
//  rsp      out  voice_index, voice_found, active_mask,
//                releasing_mask                                    valid/ready
//
// Note-on, note-off and tick words walk the voice memory one voice per cycle;
// a note-on adds a claim write after the walk, while all-off, presence and
// unused kinds skip the walk and go straight to the result.
// The key and fade memories have one read and one write port, which sets the
// one-voice-per-cycle walk. After reset a clearing pass zeroes every entry of
// the presence memory; req.ready stays low meanwhile. A stalled rsp holds its
// word while the next req word is taken and walked.
module poly_voice_allocator_release #(
    parameter int VOICES     = pva_pkg::VOICES_DEF,
    parameter int NOTES      = pva_pkg::NOTES_DEF,
    parameter int FADE_STEPS = pva_pkg::FADE_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pva_req_if.sink     req,
    pva_rsp_if.source   rsp
);
    import pva_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NIDX_W = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int KEY_W  = NIDX_W;
    localparam int FADE_W = $clog2(FADE_STEPS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CLAIM = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Control registers
    logic [2:0]         state_reg, state_next;
    logic [VIDX_W-1:0]  idx_reg, idx_next;
    logic [NIDX_W-1:0]  clr_reg, clr_next;
    logic [VOICES-1:0]  on_reg, on_next;
    logic [VOICES-1:0]  fad_reg, fad_next;
    logic               found_reg, found_next;
    logic [VIDX_W-1:0]  chosen_reg, chosen_next;
    logic               out_valid_reg, out_valid_next;

    // Held request word
    kind_t              kind_reg;
    logic [KEY_W-1:0]   note_reg;
    logic               note_ok_reg;

    // Response word
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_found_reg;
    logic [MASK_W-1:0]  out_active_reg;
    logic [MASK_W-1:0]  out_releasing_reg;

    // Memories and their registered read data
    logic [KEY_W-1:0]   key_mem  [VOICES];
    logic [FADE_W-1:0]  fade_mem [VOICES];
    logic               pres_mem [NOTES];
    logic [KEY_W-1:0]   key_rd_reg;
    logic [FADE_W-1:0]  fade_rd_reg;
    logic               pres_rd_reg;

    logic               accept;
    logic               in_note_ok;
    logic               scan_last;
    logic [VIDX_W-1:0]  voice_raddr;
    logic               hit;
    logic               sample_ok;
    logic               tick_live;
    logic [FADE_W-1:0]  fade_dec;
    logic               load_out;
    logic               pres_we;
    logic [NIDX_W-1:0]  pres_waddr;
    logic               pres_wdata;
    logic [NIDX_W-1:0]  pres_raddr;
    logic               fade_we;
    logic [VIDX_W-1:0]  fade_waddr;
    logic [FADE_W-1:0]  fade_wdata;
    logic               key_we;

    // Handshake and decode
    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign in_note_ok = ({1'b0, req.note_number} < (NOTE_W + 1)'(NOTES));
    assign scan_last  = (idx_reg == VIDX_W'(VOICES - 1));

    // Voice memory read address: voice 0 on acceptance, then one ahead of the walk
    assign voice_raddr = (state_reg == ST_SCAN && !scan_last) ? idx_reg + 1'b1 : '0;

    // Per-voice match and fade step on the voice under the walk
    assign hit       = on_reg[idx_reg] && note_ok_reg
                       && (key_rd_reg == note_reg);
    assign sample_ok = note_ok_reg && pres_rd_reg;
    assign tick_live = on_reg[idx_reg] && fad_reg[idx_reg];
    assign fade_dec  = (fade_rd_reg != '0) ? fade_rd_reg - 1'b1 : '0;

    // Presence memory ports
    assign pres_we    = (state_reg == ST_CLEAR)
                        || (accept && req.kind == KIND_PRESENCE && in_note_ok);
    assign pres_waddr = (state_reg == ST_CLEAR) ? clr_reg : req.note_number[NIDX_W-1:0];
    assign pres_wdata = (state_reg == ST_CLEAR) ? 1'b0 : req.present_flag;
    assign pres_raddr = in_note_ok ? req.note_number[NIDX_W-1:0] : '0;

    // Voice memory write ports
    assign key_we     = (state_reg == ST_CLAIM) && found_reg;
    assign fade_we    = key_we
                        || (state_reg == ST_SCAN && kind_reg == KIND_TICK && tick_live);
    assign fade_waddr = (state_reg == ST_CLAIM) ? chosen_reg : idx_reg;
    assign fade_wdata = (state_reg == ST_CLAIM) ? FADE_W'(FADE_STEPS) : fade_dec;

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Next-state logic of the sequencer and the voice flags
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        on_next        = on_reg;
        fad_next       = fad_reg;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NIDX_W'(NOTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next  = 1'b0;
                    chosen_next = '0;
                    idx_next    = '0;
                    priority if (req.kind == KIND_NOTE_ON || req.kind == KIND_NOTE_OFF
                                 || req.kind == KIND_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req.kind == KIND_ALL_OFF)
                    begin
                        on_next    = '0;
                        fad_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                unique case (kind_reg)
                    KIND_NOTE_ON:
                    begin
                        // if present, end this note's voices, pick first free one
                        if (sample_ok)
                        begin
                            if (hit)
                            begin
                                on_next[idx_reg]  = 1'b0;
                                fad_next[idx_reg] = 1'b0;
                            end
                            if ((!on_reg[idx_reg] || hit) && !found_reg)
                            begin
                                found_next  = 1'b1;
                                chosen_next = idx_reg;
                            end
                        end
                    end
                    KIND_NOTE_OFF:
                    begin
                        if (hit)
                        begin
                            fad_next[idx_reg] = 1'b1;
                        end
                    end
                    KIND_TICK:
                    begin
                        // free a voice whose fade has run out
                        if (tick_live && fade_dec == '0)
                        begin
                            on_next[idx_reg]  = 1'b0;
                            fad_next[idx_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (scan_last)
                begin
                    state_next = (kind_reg == KIND_NOTE_ON) ? ST_CLAIM : ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CLAIM:
            begin
                if (found_reg)
                begin
                    on_next[chosen_reg]  = 1'b1;
                    fad_next[chosen_reg] = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            clr_reg       <= '0;
            on_reg        <= '0;
            fad_reg       <= '0;
            found_reg     <= 1'b0;
            chosen_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
            on_reg        <= on_next;
            fad_reg       <= fad_next;
            found_reg     <= found_next;
            chosen_reg    <= chosen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request word for the walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.kind;
            note_reg    <= req.note_number[KEY_W-1:0];
            note_ok_reg <= in_note_ok;
        end
    end

    // Load the response word
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg     <= found_reg ? INDEX_W'(chosen_reg) : '0;
            out_found_reg     <= found_reg;
            out_active_reg    <= MASK_W'(on_reg);
            out_releasing_reg <= MASK_W'(on_reg & fad_reg);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.voice_index    = out_index_reg;
    assign rsp.voice_found    = out_found_reg;
    assign rsp.active_mask    = out_active_reg;
    assign rsp.releasing_mask = out_releasing_reg;

    // Presence memory
    always_ff @(posedge clk)
    begin
        if (pres_we)
        begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        if (accept)
        begin
            pres_rd_reg <= pres_mem[pres_raddr];
        end
    end

    // Voice key and fade memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[chosen_reg] <= note_reg;
        end
        if (fade_we)
        begin
            fade_mem[fade_waddr] <= fade_wdata;
        end
        key_rd_reg  <= key_mem[voice_raddr];
        fade_rd_reg <= fade_mem[voice_raddr];
    end

endmodule

@@ rtl/core/pva_checker.sv @@
// Port checker of the voice allocator and its bind to the top level.
module pva_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [pva_pkg::INDEX_W-1:0]   voice_index,
    input  logic                          voice_found,
    input  logic [pva_pkg::MASK_W-1:0]    active_mask,
    input  logic [pva_pkg::MASK_W-1:0]    releasing_mask
);
    import pva_pkg::*;

    // A fading voice is always an active voice
    a_release_in_active: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((releasing_mask & ~active_mask) == '0))
        else $error("releasing voice outside active mask");

    // Without a claim the voice index reads zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !voice_found) |-> (voice_index == '0))
        else $error("voice index set without a claim");

    // One word in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a word is in work");

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(voice_index)
            && $stable(voice_found) && $stable(active_mask) && $stable(releasing_mask)))
        else $error("stalled response word changed");

endmodule

bind poly_voice_allocator_release pva_checker u_pva_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .voice_index    (rsp.voice_index),
    .voice_found    (rsp.voice_found),
    .active_mask    (rsp.active_mask),
    .releasing_mask (rsp.releasing_mask)
);
